### hdl/lgg_pkg.sv
`default_nettype none
package lgg_pkg;

	localparam int COORD_W    = 6;
	localparam int SIZE_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_WRAP_MODE   = 2'd2
	} reg_idx_t;

	localparam logic [SIZE_W-1:0] GRID_WIDTH_RST  = 7'd64;
	localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST = 7'd64;

endpackage
`default_nettype wire

### hdl/lgg_cmd_if.sv
`default_nettype none
interface lgg_cmd_if import lgg_pkg::*;;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic               value;

	modport source (output valid, output op, output col, output row, output value, input ready);
	modport sink   (input valid, input op, input col, input row, input value, output ready);
endinterface
`default_nettype wire

### hdl/lgg_rsp_if.sv
`default_nettype none
interface lgg_rsp_if;
	logic valid;
	logic ready;
	logic cell_res;
	logic in_range;

	modport source (output valid, output cell_res, output in_range, input ready);
	modport sink   (input valid, input cell_res, input in_range, output ready);
endinterface
`default_nettype wire

### hdl/lgg_cfg_if.sv
`default_nettype none
interface lgg_cfg_if import lgg_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/life_grid_generation_step.sv
`default_nettype none
// Game of Life grid (rule B3/S23) of up to MAX_WIDTH x MAX_HEIGHT cells, one row per RAM
// word, with a per-row valid bit so that reset and the clear operation take effect at once.
// Each cmd transaction gets exactly one rsp transaction. A cell write or read goes from
// acceptance through read, modify/select and result steps to the result register; a clear
// goes straight to the result. An advance uses one row-wide neighbor count and rule unit that
// updates one row per cycle, fed by the single RAM read port one row ahead, after the steps
// that fetch the last row and the first row. cmd is not ready until the result is registered;
// a waiting result does not block the next command. Configuration writes are always ready
// and must only be issued while the block is idle.
module life_grid_generation_step import lgg_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input wire logic   clk,
	input wire logic   arst_n,
	lgg_cmd_if.sink    cmd,
	lgg_rsp_if.source  rsp,
	lgg_cfg_if.sink    cfg
);

	localparam int CA = $clog2(MAX_WIDTH);
	localparam int RA = $clog2(MAX_HEIGHT);
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int HB = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ACC  = 6'b000010,
		S_ADV0 = 6'b000100,
		S_ADV1 = 6'b001000,
		S_ROW  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	typedef logic [MAX_WIDTH-1:0] row_t;

	state_t             state_q;
	op_t                op_q;
	logic [CA-1:0]      col_q;
	logic [RA-1:0]      row_q;
	logic               val_q;
	logic               inside_q;
	logic [RA-1:0]      r_q;
	row_t               above_q;
	row_t               cur_q;
	row_t               first_q;
	logic               pcell_q;
	logic               pok_q;
	logic               rsp_valid_q;
	logic               rsp_cell_q;
	logic               rsp_ok_q;
	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;
	logic               wrap_q;
	logic [MAX_HEIGHT-1:0] valid_q;
	logic               rd_valid_q;

	logic [WB-1:0]      w_eff;
	logic [HB-1:0]      h_eff;
	logic [CA-1:0]      wl;
	logic [RA-1:0]      last_row;
	logic               in_grid;
	logic               has_below;
	row_t               ram_rdata;
	row_t               rd_row;
	row_t               below_row;
	row_t               next_row;
	row_t               poke_row;
	logic               ram_we;
	logic [RA-1:0]      ram_waddr;
	logic [RA-1:0]      ram_raddr;
	row_t               ram_wdata;

	function automatic row_t left_of(input row_t r, input logic torus, input logic [CA-1:0] w_last);
		row_t v;
		v    = r << 1;
		v[0] = torus & r[w_last];
		return v;
	endfunction

	function automatic row_t right_of(input row_t r, input logic torus, input logic [CA-1:0] w_last);
		row_t v;
		v         = r >> 1;
		v[w_last] = torus & r[0];
		return v;
	endfunction

	// effective grid size
	always_comb begin
		if (width_q == '0) begin
			w_eff = WB'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HB'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = HB'(MAX_HEIGHT);
		end else begin
			h_eff = HB'(height_q);
		end
	end

	assign wl        = CA'(w_eff - WB'(1));
	assign last_row  = RA'(h_eff - HB'(1));
	assign in_grid   = (int'(cmd.col) < int'(w_eff)) && (int'(cmd.row) < int'(h_eff));
	assign rd_row    = ram_rdata & {MAX_WIDTH{rd_valid_q}};
	assign has_below = (int'(r_q) + 1) < int'(h_eff);
	assign below_row = has_below ? rd_row : (wrap_q ? first_q : '0);

	// row-wide neighbor count and rule
	always_comb begin
		row_t       al;
		row_t       ar;
		row_t       cl;
		row_t       cr;
		row_t       bl;
		row_t       br;
		logic [3:0] n;
		al = left_of(above_q, wrap_q, wl);
		ar = right_of(above_q, wrap_q, wl);
		cl = left_of(cur_q, wrap_q, wl);
		cr = right_of(cur_q, wrap_q, wl);
		bl = left_of(below_row, wrap_q, wl);
		br = right_of(below_row, wrap_q, wl);
		for (int x = 0; x < MAX_WIDTH; x++) begin
			n = {3'b0, al[x]} + {3'b0, above_q[x]} + {3'b0, ar[x]} + {3'b0, cl[x]}
				+ {3'b0, cr[x]} + {3'b0, bl[x]} + {3'b0, below_row[x]} + {3'b0, br[x]};
			if (x < int'(w_eff)) begin
				next_row[x] = (n == 4'd3) || ((n == 4'd2) && cur_q[x]);
			end else begin
				next_row[x] = cur_q[x];
			end
		end
	end

	always_comb begin
		poke_row        = rd_row;
		poke_row[col_q] = val_q;
	end

	// ram port control
	always_comb begin
		ram_raddr = RA'(cmd.row);
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = poke_row;
		case (state_q)
			S_IDLE: begin
				if (op_t'(cmd.op) == OP_ADVANCE) begin
					ram_raddr = last_row;
				end
			end
			S_ACC: begin
				ram_we = (op_q == OP_WRITE) && inside_q;
			end
			S_ADV0: begin
				ram_raddr = '0;
			end
			S_ADV1: begin
				ram_raddr = RA'(1);
			end
			S_ROW: begin
				ram_raddr = r_q + RA'(2);
				ram_we    = 1'b1;
				ram_waddr = r_q;
				ram_wdata = next_row;
			end
			default: begin
			end
		endcase
	end

	lgg_ram #(
		.WIDTH (MAX_WIDTH),
		.DEPTH (MAX_HEIGHT)
	) u_lgg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			width_q     <= GRID_WIDTH_RST;
			height_q    <= GRID_HEIGHT_RST;
			wrap_q      <= 1'b0;
			valid_q     <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[ram_raddr];
			if (cfg.valid) begin
				case (reg_idx_t'(cfg.index))
					REG_GRID_WIDTH:  width_q  <= cfg.data;
					REG_GRID_HEIGHT: height_q <= cfg.data;
					REG_WRAP_MODE:   wrap_q   <= cfg.data[0];
					default: begin
					end
				endcase
			end
			if (rsp_valid_q && rsp.ready && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q     <= op_t'(cmd.op);
						col_q    <= CA'(cmd.col);
						row_q    <= RA'(cmd.row);
						val_q    <= cmd.value;
						inside_q <= in_grid;
						pcell_q  <= 1'b0;
						pok_q    <= 1'b1;
						if (op_t'(cmd.op) inside {OP_WRITE, OP_READ}) begin
							state_q <= S_ACC;
						end else if (op_t'(cmd.op) == OP_ADVANCE) begin
							state_q <= S_ADV0;
						end else begin
							valid_q <= '0;
							state_q <= S_FIN;
						end
					end
				end
				S_ACC: begin
					pcell_q <= (op_q == OP_READ) && inside_q && rd_row[col_q];
					pok_q   <= inside_q;
					state_q <= S_FIN;
				end
				S_ADV0: begin
					above_q <= wrap_q ? rd_row : '0;
					state_q <= S_ADV1;
				end
				S_ADV1: begin
					cur_q   <= rd_row;
					first_q <= rd_row;
					r_q     <= '0;
					state_q <= S_ROW;
				end
				S_ROW: begin
					above_q <= cur_q;
					cur_q   <= rd_row;
					r_q     <= r_q + RA'(1);
					if (r_q == last_row) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_cell_q  <= pcell_q;
						rsp_ok_q    <= pok_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready    = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.cell_res = rsp_cell_q;
	assign rsp.in_range = rsp_ok_q;

endmodule
`default_nettype wire

### hdl/lgg_ram.sv
`default_nettype none
module lgg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hdl/lgg_checker.sv
`default_nettype none
module lgg_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic rsp_cell_res,
	input wire logic rsp_in_range
);

	// one command in flight at a time
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("cmd ready right after a transaction");

	// a live cell can only come from an in-range read
	a_cell_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_cell_res |-> rsp_in_range)
		else $error("cell_res set on an out-of-range result");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_cell_res) && $stable(rsp_in_range))
		else $error("rsp payload changed while stalled");

endmodule

bind life_grid_generation_step lgg_checker u_lgg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_cell_res (rsp.cell_res),
	.rsp_in_range (rsp.in_range)
);
`default_nettype wire
